// ----- rtl/dglb_pkg.sv -----
// Shared types and constants for the double-byte line breaker.
package dglb_pkg;

   localparam int TEXT_W     = 8;
   localparam int BYTES_W    = 10;
   localparam int PIXELS_W   = 12;
   localparam int GLYPH_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   localparam int OPQ_DEPTH = 4;
   localparam int RES_DEPTH = 4;

   localparam logic [BYTES_W-1:0]  BYTES_MAX    = '1;
   localparam logic [PIXELS_W-1:0] PIXELS_MAX   = '1;
   localparam logic [TEXT_W-1:0]   NEWLINE_BYTE = 8'h0A;

   localparam logic [PIXELS_W-1:0] MAX_LINE_WIDTH_RST     = 12'd480;
   localparam logic [GLYPH_W-1:0]  WIDE_GLYPH_WIDTH_RST   = 7'd16;
   localparam logic [GLYPH_W-1:0]  NARROW_GLYPH_WIDTH_RST = 7'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_GLYPH_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NARROW_GLYPH_WIDTH = 2'd2;

   typedef enum logic [1:0] {
      OP_NARROW  = 2'd0,
      OP_LEAD    = 2'd1,
      OP_TRAIL   = 2'd2,
      OP_NEWLINE = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        fin;
   } op_type;

   typedef struct packed {
      logic [BYTES_W-1:0]  bytes;
      logic [PIXELS_W-1:0] pixels;
      logic                done;
   } line_type;

endpackage

// ----- rtl/dglb_front.sv -----
// Front end: accepts text bytes and classifies them into glyph operations.
module dglb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dglb_pkg::TEXT_W-1:0]  req_tdata,
   input  logic                         req_tlast,
   input  logic                         opq_full,
   output logic                         opq_push,
   output dglb_pkg::op_type             opq_op
);

   logic awaiting_trail_ff;
   logic awaiting_trail_in;

   assign req_tready = !opq_full;
   assign opq_push   = req_tvalid && req_tready;

   always_comb begin
      opq_op.fin = req_tlast;
      if (awaiting_trail_ff) begin
         opq_op.kind = dglb_pkg::OP_TRAIL;
      end else if (req_tdata[dglb_pkg::TEXT_W-1]) begin
         opq_op.kind = dglb_pkg::OP_LEAD;
      end else if (req_tdata == dglb_pkg::NEWLINE_BYTE) begin
         opq_op.kind = dglb_pkg::OP_NEWLINE;
      end else begin
         opq_op.kind = dglb_pkg::OP_NARROW;
      end
   end

   // a lead byte that ends the text leaves nothing pending
   always_comb begin
      awaiting_trail_in = awaiting_trail_ff;
      if (opq_push) begin
         awaiting_trail_in = (opq_op.kind == dglb_pkg::OP_LEAD) && !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_trail_ff <= 1'b0;
      end else begin
         awaiting_trail_ff <= awaiting_trail_in;
      end
   end

endmodule

// ----- rtl/dglb_opq.sv -----
// Small queue of classified glyph operations between front and back end.
module dglb_opq #(
   parameter int Depth = dglb_pkg::OPQ_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dglb_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output dglb_pkg::op_type pop_op,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   dglb_pkg::op_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign full   = (count_ff == CntW'(Depth));
   assign empty  = (count_ff == '0);
   assign pop_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/dglb_back.sv -----
// Back end: line state, width fit test, config registers and result buffer.
module dglb_back #(
   parameter int ResDepth = dglb_pkg::RES_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dglb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dglb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             opq_empty,
   input  dglb_pkg::op_type                 opq_op,
   output logic                             opq_pop,
   output dglb_pkg::line_type               rsp_line,
   output logic                             rsp_valid,
   input  logic                             rsp_ready
);

   localparam int PtrW = (ResDepth > 1) ? $clog2(ResDepth) : 1;
   localparam int CntW = $clog2(ResDepth + 1);
   localparam int BW   = dglb_pkg::BYTES_W;
   localparam int PW   = dglb_pkg::PIXELS_W;
   localparam int GW   = dglb_pkg::GLYPH_W;

   logic [PW-1:0] max_width_ff;
   logic [GW-1:0] wide_width_ff;
   logic [GW-1:0] narrow_width_ff;

   logic [BW-1:0] bytes_ff, bytes_in;
   logic [PW-1:0] pixels_ff, pixels_in;

   dglb_pkg::line_type res_mem_ff [ResDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   logic               rsp_fire;
   logic               narrow_op;
   logic               no_width;
   logic [GW-1:0]      glyph_px;
   logic [PW:0]        fit_sum;
   logic [PW:0]        add_sum;
   logic               room_emit;
   logic               close_emit;
   logic [BW-1:0]      base_bytes;
   logic [PW-1:0]      base_pixels;
   logic [BW-1:0]      new_bytes;
   logic [PW-1:0]      new_pixels;
   dglb_pkg::line_type line_a;
   dglb_pkg::line_type line_b;
   logic [PtrW-1:0]    b_slot;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(ResDepth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff    <= dglb_pkg::MAX_LINE_WIDTH_RST;
         wide_width_ff   <= dglb_pkg::WIDE_GLYPH_WIDTH_RST;
         narrow_width_ff <= dglb_pkg::NARROW_GLYPH_WIDTH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dglb_pkg::CSR_MAX_LINE_WIDTH: begin
               max_width_ff <= csr_data[PW-1:0];
            end
            dglb_pkg::CSR_WIDE_GLYPH_WIDTH: begin
               wide_width_ff <= csr_data[GW-1:0];
            end
            dglb_pkg::CSR_NARROW_GLYPH_WIDTH: begin
               narrow_width_ff <= csr_data[GW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // room for two results must exist before an operation is taken
   assign opq_pop  = !opq_empty && (count_ff <= CntW'(ResDepth - 2));
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      narrow_op = (opq_op.kind == dglb_pkg::OP_NARROW);
      no_width  = (opq_op.kind == dglb_pkg::OP_LEAD) ||
                  (opq_op.kind == dglb_pkg::OP_NEWLINE);
      glyph_px  = narrow_op ? narrow_width_ff : wide_width_ff;
      fit_sum   = {1'b0, pixels_ff} + (PW + 1)'(glyph_px);
      room_emit = ((opq_op.kind == dglb_pkg::OP_LEAD) || narrow_op) &&
                  (bytes_ff != '0) && (fit_sum > {1'b0, max_width_ff});
      close_emit = (opq_op.kind == dglb_pkg::OP_NEWLINE) || opq_op.fin;

      base_bytes  = room_emit ? '0 : bytes_ff;
      base_pixels = room_emit ? '0 : pixels_ff;
      // on an empty line the sum is the glyph width alone
      add_sum     = room_emit ? (PW + 1)'(glyph_px) : fit_sum;

      new_bytes = (base_bytes == dglb_pkg::BYTES_MAX) ? base_bytes
                                                      : base_bytes + BW'(1);
      if (no_width) begin
         new_pixels = base_pixels;
      end else if (add_sum[PW]) begin
         new_pixels = dglb_pkg::PIXELS_MAX;
      end else begin
         new_pixels = add_sum[PW-1:0];
      end

      line_a.bytes  = bytes_ff;
      line_a.pixels = pixels_ff;
      line_a.done   = 1'b0;
      line_b.bytes  = new_bytes;
      line_b.pixels = new_pixels;
      line_b.done   = opq_op.fin;

      bytes_in  = bytes_ff;
      pixels_in = pixels_ff;
      if (opq_pop) begin
         bytes_in  = close_emit ? '0 : new_bytes;
         pixels_in = close_emit ? '0 : new_pixels;
      end

      b_slot    = room_emit ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (opq_pop) begin
         wr_ptr_in = close_emit ? ptr_inc(b_slot) : b_slot;
      end
      rd_ptr_in = rsp_fire ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(opq_pop && room_emit) + CntW'(opq_pop && close_emit)
                  - CntW'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (opq_pop && room_emit) begin
         res_mem_ff[wr_ptr_ff] <= line_a;
      end
      if (opq_pop && close_emit) begin
         res_mem_ff[b_slot] <= line_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff  <= '0;
         pixels_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         bytes_ff  <= bytes_in;
         pixels_ff <= pixels_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_line  = res_mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/dbcs_greedy_line_breaker_top.sv -----
// Path: a byte is registered in the op queue, then the result for the line it closes is registered in
// the result buffer; ops are taken only while at most two results wait in the result buffer.
// Throughput: one text byte per cycle while the op queue is not full; a byte that closes two lines yields two results.
// The op queue and the four-entry result buffer let either side stall without blocking the other.
// Reset (synchronous, active high) empties both queues, clears the open line and loads
// max_line_width 480, wide_glyph_width 16, narrow_glyph_width 8.
module dbcs_greedy_line_breaker_top #(
   parameter int OpqDepth = dglb_pkg::OPQ_DEPTH,
   parameter int ResDepth = dglb_pkg::RES_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dglb_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] text_byte
   input  logic                                req_tlast,  // is_final_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dglb_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [9:0] line_bytes, [21:10] line_pixels
   output logic                                rsp_tlast,  // text_done
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dglb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dglb_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic               opq_push;
   logic               opq_pop;
   logic               opq_full;
   logic               opq_empty;
   dglb_pkg::op_type   push_op;
   dglb_pkg::op_type   pop_op;
   dglb_pkg::line_type rsp_line;

   dglb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .opq_full   (opq_full),
      .opq_push   (opq_push),
      .opq_op     (push_op)
   );

   dglb_opq #(
      .Depth (OpqDepth)
   ) u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (opq_push),
      .push_op (push_op),
      .full    (opq_full),
      .pop     (opq_pop),
      .pop_op  (pop_op),
      .empty   (opq_empty)
   );

   dglb_back #(
      .ResDepth (ResDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .opq_empty (opq_empty),
      .opq_op    (pop_op),
      .opq_pop   (opq_pop),
      .rsp_line  (rsp_line),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {2'b00, rsp_line.pixels, rsp_line.bytes};
   assign rsp_tlast = rsp_line.done;

endmodule
